[hdl/fwa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fwa_pkg;

    localparam int CFG_W  = 5;
    localparam int USED_W = 5;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic take;
        logic div_start;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_valid;
        logic flushing;
        logic due;
        logic last_pos;
        logic div_busy;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[hdl/fwa_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fwa_in_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          is_final;

    modport source (output valid, sample, is_final, input ready);
    modport sink (input valid, sample, is_final, output ready);
endinterface

interface fwa_out_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   average;
    logic [fwa_pkg::USED_W-1:0]      samples_used;
    logic                            end_of_column;

    modport source (output valid, average, samples_used, end_of_column, input ready);
    modport sink (input valid, average, samples_used, end_of_column, output ready);
endinterface

`default_nettype wire

[hdl/fwa_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module fwa_div #(
    parameter int SUM_W = 37,
    parameter int CNT_W = 5
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0]        i_divisor,
    output logic                         o_busy,
    output logic signed [SUM_W-1:0]      o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [STEP_W-1:0] r_steps, n_steps;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_div, n_div;
    logic              r_neg, n_neg;

    logic [CNT_W:0]    shifted;
    logic              fits;

    // restoring division, one quotient bit per cycle
    always_comb begin
        shifted = {r_rem, r_quo[SUM_W-1]};
        fits    = (shifted >= {1'b0, r_div});
        n_steps = r_steps;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_neg   = r_neg;
        if (i_start) begin
            n_steps = STEP_W'(SUM_W);
            n_neg   = i_dividend[SUM_W-1];
            n_quo   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            n_rem   = '0;
            n_div   = i_divisor;
        end else if (r_steps != '0) begin
            n_steps = r_steps - STEP_W'(1);
            n_quo   = {r_quo[SUM_W-2:0], fits};
            n_rem   = fits ? CNT_W'(shifted - {1'b0, r_div}) : CNT_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else begin
            r_steps <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    assign o_busy     = (r_steps != '0);
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

`default_nettype wire

[hdl/fwa_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module fwa_dp #(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    fwa_in_if.sink                             i_sample_if,
    fwa_out_if.source                          o_result_if,
    input  wire logic                          i_cfg_we,
    input  wire logic [fwa_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire fwa_pkg::t_ctrl_cmd            i_cmd,
    output fwa_pkg::t_dp_status                o_status
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W = (CNT_W > fwa_pkg::CFG_W) ? CNT_W : fwa_pkg::CFG_W;

    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rd;

    logic [fwa_pkg::CFG_W-1:0] r_window;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]          r_held, n_held;
    logic [IDX_W-1:0]          r_oldest, n_oldest;
    logic [IDX_W-1:0]          r_wr, n_wr;
    logic                      r_final, n_final;

    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_avg;
    logic [fwa_pkg::USED_W-1:0]    r_used;
    logic                          r_eoc;

    logic                          push;
    logic                          last_pos;
    logic [CMP_W-1:0]              win_eff;
    logic                          div_busy;
    logic signed [SUM_W-1:0]       quotient;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] ptr);
        logic [IDX_W-1:0] nxt;
        nxt = (ptr == IDX_W'(MAX_WINDOW - 1)) ? '0 : ptr + IDX_W'(1);
        return nxt;
    endfunction

    fwa_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_held),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign push     = i_cmd.take && i_sample_if.valid;
    assign last_pos = r_final && (r_held == CNT_W'(1));

    always_comb begin
        if (r_window == '0) begin
            win_eff = CMP_W'(1);
        end else if (CMP_W'(r_window) > CMP_W'(MAX_WINDOW)) begin
            win_eff = CMP_W'(MAX_WINDOW);
        end else begin
            win_eff = CMP_W'(r_window);
        end
    end

    always_comb begin
        n_sum       = r_sum;
        n_held      = r_held;
        n_oldest    = r_oldest;
        n_wr        = r_wr;
        n_final     = r_final;
        n_out_valid = r_out_valid;
        if (o_result_if.ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_we) begin
            n_sum    = '0;
            n_held   = '0;
            n_oldest = '0;
            n_wr     = '0;
            n_final  = 1'b0;
        end else if (push) begin
            n_sum   = r_sum + SUM_W'(i_sample_if.sample);
            n_held  = r_held + CNT_W'(1);
            n_wr    = ring_next(r_wr);
            n_final = i_sample_if.is_final;
        end else if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            if (last_pos) begin
                n_sum    = '0;
                n_held   = '0;
                n_oldest = '0;
                n_wr     = '0;
                n_final  = 1'b0;
            end else begin
                n_sum    = r_sum - SUM_W'(r_rd);
                n_held   = r_held - CNT_W'(1);
                n_oldest = ring_next(r_oldest);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= fwa_pkg::WINDOW_RESET;
            r_sum       <= '0;
            r_held      <= '0;
            r_oldest    <= '0;
            r_wr        <= '0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            r_sum       <= n_sum;
            r_held      <= n_held;
            r_oldest    <= n_oldest;
            r_wr        <= n_wr;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    // ring store
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_sample_if.sample;
        end
        r_rd <= r_mem[r_oldest];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_avg  <= SAMPLE_BITS'(quotient);
            r_used <= fwa_pkg::USED_W'(r_held);
            r_eoc  <= last_pos;
        end
    end

    assign i_sample_if.ready          = i_cmd.take;
    assign o_result_if.valid          = r_out_valid;
    assign o_result_if.average        = r_avg;
    assign o_result_if.samples_used   = r_used;
    assign o_result_if.end_of_column  = r_eoc;

    assign o_status.in_valid = i_sample_if.valid;
    assign o_status.flushing = r_final;
    assign o_status.due      = r_final || (CMP_W'(r_held) >= win_eff);
    assign o_status.last_pos = last_pos;
    assign o_status.div_busy = div_busy;
    assign o_status.out_free = !r_out_valid || o_result_if.ready;

endmodule

`default_nettype wire

[hdl/fwa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fwa_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire fwa_pkg::t_dp_status  i_status,
    output fwa_pkg::t_ctrl_cmd        o_cmd
);

    fwa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            fwa_pkg::ST_IDLE: begin
                o_cmd.take = 1'b1;
                if (i_status.in_valid) begin
                    n_state = fwa_pkg::ST_CHECK;
                end
            end
            fwa_pkg::ST_CHECK: begin
                if (i_status.due) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = fwa_pkg::ST_DIV;
                end else begin
                    n_state = fwa_pkg::ST_IDLE;
                end
            end
            fwa_pkg::ST_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = fwa_pkg::ST_EMIT;
                end
            end
            fwa_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    // keep flushing until the column's final position
                    if (i_status.flushing && !i_status.last_pos) begin
                        n_state = fwa_pkg::ST_CHECK;
                    end else begin
                        n_state = fwa_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = fwa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/forward_window_average.sv]
// Forward moving average over one column of samples. For each position j the block returns
// the mean of samples j..j+N-1 (N = window_length, 0 taken as 1, capped at MAX_WINDOW), as
// signed fixed point truncated toward zero, once sample j+N-1 has been taken; the sample
// marked is_final flushes all remaining positions over the samples actually present, the
// last one flagged end_of_column. Writing window_length abandons the column in progress.
// Each result is computed by a bit-serial divider working on the sum, one quotient bit a cycle,
// over SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) + 1 bits (37 with the defaults); each further
// position flushed by the final sample divides anew, and a new result is held back while the
// output register waits on a stalled consumer. No sample is taken from the start of a divide
// until its result is loaded.
// A waiting result sits in an output register while the next sample is taken.
`timescale 1ns / 1ps
`default_nettype none

module forward_window_average #(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    fwa_in_if.sink                         i_sample_if,
    fwa_out_if.source                      o_result_if,
    input  wire logic                      i_cfg_we,
    input  wire logic [fwa_pkg::CFG_W-1:0] i_cfg_wdata
);

    fwa_pkg::t_ctrl_cmd  cmd;
    fwa_pkg::t_dp_status status;

    fwa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    fwa_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_if (i_sample_if),
        .o_result_if (o_result_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    a_no_take_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.div_busy |-> !i_sample_if.ready)
        else $error("sample taken while divider busy");

    a_emit_after_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !status.div_busy)
        else $error("result loaded before quotient ready");

    a_end_has_one_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_if.valid && o_result_if.end_of_column |->
            o_result_if.samples_used == fwa_pkg::USED_W'(1))
        else $error("final position averaged over more than one sample");

    a_result_follows_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_if.valid) |-> $past(cmd.emit))
        else $error("result appeared without an emit");

endmodule

`default_nettype wire

[tb/forward_window_average_tb.sv]
`timescale 1ns / 1ps

module forward_window_average_tb;

    localparam int MAX_WIN       = 16;
    localparam int SAMPLE_W      = 32;
    localparam int RANDOM_ITEMS  = 260;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 60;
    localparam int IDLE_LIMIT    = 5000;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]         average;
        logic [fwa_pkg::USED_W-1:0]         samples_used;
        logic                               end_of_column;
    } t_average;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [fwa_pkg::CFG_W-1:0] i_cfg_wdata;

    fwa_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
    fwa_out_if #(.SAMPLE_BITS(SAMPLE_W)) res_if ();

    forward_window_average #(
        .MAX_WINDOW  (MAX_WIN),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_if (in_if),
        .o_result_if (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // column model
    logic signed [SAMPLE_W-1:0] held_samples [MAX_WIN];
    longint                     column_sum;
    int unsigned                column_count;
    int unsigned                column_head;
    logic [fwa_pkg::CFG_W-1:0]  window_len;

    t_average pending_averages [$];
    int       mismatch_count;
    int       items_sent;
    bit       gaps_off;
    bit       stalls_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_column();
        column_sum   = 0;
        column_count = 0;
        column_head  = 0;
    endfunction

    function automatic int unsigned window_span(input logic [fwa_pkg::CFG_W-1:0] len);
        if (len == 0) return 1;
        if (len > MAX_WIN) return MAX_WIN;
        return len;
    endfunction

    function automatic void emit_oldest(input logic last);
        t_average avg;
        longint   mean;
        mean = column_sum / longint'(column_count);
        avg.average       = mean[SAMPLE_W-1:0];
        avg.samples_used  = column_count[fwa_pkg::USED_W-1:0];
        avg.end_of_column = last;
        pending_averages = {pending_averages, avg};
        column_sum  -= held_samples[column_head];
        column_head  = (column_head + 1) % MAX_WIN;
        column_count--;
    endfunction

    function automatic void predict_averages(input logic signed [SAMPLE_W-1:0] value,
                                             input logic last_sample);
        int unsigned span;
        span = window_span(window_len);
        held_samples[(column_head + column_count) % MAX_WIN] = value;
        column_sum += value;
        column_count++;
        if (last_sample) begin
            while (column_count > 0) emit_oldest(column_count == 1);
            clear_column();
        end else if (column_count >= span) begin
            emit_oldest(1'b0);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (gaps_off) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int pick_stall();
        int r;
        if (stalls_off) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic last_sample);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.sample   <= value;
        in_if.is_final <= last_sample;
        do @(posedge i_clk); while (!in_if.ready);
        predict_averages(value, last_sample);
        items_sent++;
    endtask

    task automatic release_input();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        release_input();
        while (pending_averages.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [fwa_pkg::CFG_W-1:0] len);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        window_len = len;
        clear_column();
    endtask

    task automatic test_default_window();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_zero_window();
        write_window(fwa_pkg::CFG_W'(0));
        send_sample(32'h0001_8000, 1'b0);
        send_sample(32'hFFFE_8000, 1'b1);
    endtask

    // full window of largest samples, then a flush
    task automatic test_saturated_window();
        write_window(fwa_pkg::CFG_W'(31));
        repeat (MAX_WIN) send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
    endtask

    task automatic test_abandon_and_pause();
        write_window(fwa_pkg::CFG_W'(4));
        repeat (5) send_sample(random_sample(), 1'b0);
        wait_drained();
        send_sample(random_sample(), 1'b0);
        write_window(fwa_pkg::CFG_W'(3));
        send_sample(random_sample(), 1'b1);
    endtask

    task automatic test_random_columns();
        int                        target;
        int                        columns;
        int                        col_len;
        int unsigned               span;
        bit                        broken;
        logic [fwa_pkg::CFG_W-1:0] len;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            case ($urandom_range(0, 9))
                0: len = fwa_pkg::CFG_W'($urandom_range(17, 31));
                1: len = ($urandom_range(0, 1) != 0) ? fwa_pkg::CFG_W'(0) : fwa_pkg::CFG_W'(31);
                2: len = fwa_pkg::CFG_W'(MAX_WIN);
                default: len = fwa_pkg::CFG_W'($urandom_range(1, MAX_WIN));
            endcase
            write_window(len);
            span       = window_span(len);
            gaps_off   = ($urandom_range(0, 3) == 0);
            stalls_off = ($urandom_range(0, 3) == 0);
            columns    = $urandom_range(1, 4);
            for (int c = 0; c < columns; c++) begin
                if ($urandom_range(0, 5) == 0) col_len = $urandom_range(1, 40);
                else col_len = $urandom_range(1, span + 3);
                broken = (c == columns - 1) && ($urandom_range(0, 3) == 0);
                for (int k = 0; k < col_len; k++) begin
                    if ($urandom_range(0, 59) == 0) wait_drained();
                    send_sample(random_sample(), (k == col_len - 1) && !broken);
                end
            end
        end
        gaps_off   = 1'b0;
        stalls_off = 1'b0;
    endtask

    initial begin : result_sink
        int       stall;
        t_average want;
        stall = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (pending_averages.size() == 0) begin
                    $display("%0t: unexpected transfer, average %0d used %0d end %0b",
                             $time, $signed(res_if.average), res_if.samples_used,
                             res_if.end_of_column);
                    mismatch_count++;
                end else begin
                    want = pending_averages.pop_front();
                    if (res_if.average !== want.average) begin
                        $display("%0t: average expected %0d actual %0d", $time,
                                 $signed(want.average), $signed(res_if.average));
                        mismatch_count++;
                    end
                    if (res_if.samples_used !== want.samples_used) begin
                        $display("%0t: samples_used expected %0d actual %0d", $time,
                                 want.samples_used, res_if.samples_used);
                        mismatch_count++;
                    end
                    if (res_if.end_of_column !== want.end_of_column) begin
                        $display("%0t: end_of_column expected %0b actual %0b", $time,
                                 want.end_of_column, res_if.end_of_column);
                        mismatch_count++;
                    end
                end
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
                stall = pick_stall();
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        items_sent     = 0;
        gaps_off       = 1'b0;
        stalls_off     = 1'b0;
        window_len     = fwa_pkg::WINDOW_RESET;
        clear_column();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        in_if.valid    <= 1'b0;
        in_if.sample   <= '0;
        in_if.is_final <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_window();
        test_zero_window();
        test_saturated_window();
        test_abandon_and_pause();
        test_random_columns();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_averages.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_averages.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[forward_window_average.f]
hdl/fwa_pkg.sv
hdl/fwa_stream_if.sv
hdl/fwa_div.sv
hdl/fwa_dp.sv
hdl/fwa_ctrl.sv
hdl/forward_window_average.sv
tb/forward_window_average_tb.sv
